@@ rtl/qrci_pkg.sv @@
// Package: QR codeword interleave address tables, types and divider step.
package qrci_pkg;

  localparam int unsigned WordW   = 12;  // codeword index width
  localparam int unsigned BlockW  = 7;   // block count width
  localparam int unsigned VersW   = 6;
  localparam int unsigned LevelW  = 2;
  localparam int unsigned IndexW  = 15;
  localparam int unsigned VersMax = 40;
  localparam int unsigned Levels  = 4;

  // Fixed function-pattern module counts
  localparam logic [15:0] FinderMods = 16'(8 * 8 * 3);
  localparam logic [15:0] VinfoMods  = 16'(6 * 3 * 2);
  localparam logic [15:0] FormatMods = 16'(15 * 2 + 1);
  localparam logic [7:0]  SideBase   = 8'd17;

  localparam logic [WordW-1:0] DATA_CW_ROM [VersMax][Levels] = '{
    '{12'd19, 12'd16, 12'd13, 12'd9},       '{12'd34, 12'd28, 12'd22, 12'd16},
    '{12'd55, 12'd44, 12'd34, 12'd26},      '{12'd80, 12'd64, 12'd48, 12'd36},
    '{12'd108, 12'd86, 12'd62, 12'd46},     '{12'd136, 12'd108, 12'd76, 12'd60},
    '{12'd156, 12'd124, 12'd88, 12'd66},    '{12'd194, 12'd154, 12'd110, 12'd86},
    '{12'd232, 12'd182, 12'd132, 12'd100},  '{12'd274, 12'd216, 12'd154, 12'd122},
    '{12'd324, 12'd254, 12'd180, 12'd140},  '{12'd370, 12'd290, 12'd206, 12'd158},
    '{12'd428, 12'd334, 12'd244, 12'd180},  '{12'd461, 12'd365, 12'd261, 12'd197},
    '{12'd523, 12'd415, 12'd295, 12'd223},  '{12'd589, 12'd453, 12'd325, 12'd253},
    '{12'd647, 12'd507, 12'd367, 12'd283},  '{12'd721, 12'd563, 12'd397, 12'd313},
    '{12'd795, 12'd627, 12'd445, 12'd341},  '{12'd861, 12'd669, 12'd485, 12'd385},
    '{12'd932, 12'd714, 12'd512, 12'd406},  '{12'd1006, 12'd782, 12'd568, 12'd442},
    '{12'd1094, 12'd860, 12'd614, 12'd464}, '{12'd1174, 12'd914, 12'd664, 12'd514},
    '{12'd1276, 12'd1000, 12'd718, 12'd538}, '{12'd1370, 12'd1062, 12'd754, 12'd596},
    '{12'd1468, 12'd1128, 12'd808, 12'd628}, '{12'd1531, 12'd1193, 12'd871, 12'd661},
    '{12'd1631, 12'd1267, 12'd911, 12'd701}, '{12'd1735, 12'd1373, 12'd985, 12'd745},
    '{12'd1843, 12'd1455, 12'd1033, 12'd793}, '{12'd1955, 12'd1541, 12'd1115, 12'd845},
    '{12'd2071, 12'd1631, 12'd1171, 12'd901}, '{12'd2191, 12'd1725, 12'd1231, 12'd961},
    '{12'd2306, 12'd1812, 12'd1286, 12'd986}, '{12'd2434, 12'd1914, 12'd1354, 12'd1054},
    '{12'd2566, 12'd1992, 12'd1426, 12'd1096}, '{12'd2702, 12'd2102, 12'd1502, 12'd1142},
    '{12'd2812, 12'd2216, 12'd1582, 12'd1222}, '{12'd2956, 12'd2334, 12'd1666, 12'd1276}
  };

  localparam logic [BlockW-1:0] BLOCKS [VersMax][Levels] = '{
    '{7'd1, 7'd1, 7'd1, 7'd1},     '{7'd1, 7'd1, 7'd1, 7'd1},
    '{7'd1, 7'd1, 7'd2, 7'd2},     '{7'd1, 7'd2, 7'd2, 7'd4},
    '{7'd1, 7'd2, 7'd4, 7'd4},     '{7'd2, 7'd4, 7'd4, 7'd4},
    '{7'd2, 7'd4, 7'd6, 7'd5},     '{7'd2, 7'd4, 7'd6, 7'd6},
    '{7'd2, 7'd5, 7'd8, 7'd8},     '{7'd4, 7'd5, 7'd8, 7'd8},
    '{7'd4, 7'd5, 7'd8, 7'd11},    '{7'd4, 7'd8, 7'd10, 7'd11},
    '{7'd4, 7'd9, 7'd12, 7'd16},   '{7'd4, 7'd9, 7'd16, 7'd16},
    '{7'd6, 7'd10, 7'd12, 7'd18},  '{7'd6, 7'd10, 7'd17, 7'd16},
    '{7'd6, 7'd11, 7'd16, 7'd19},  '{7'd6, 7'd13, 7'd18, 7'd21},
    '{7'd7, 7'd14, 7'd21, 7'd25},  '{7'd8, 7'd16, 7'd20, 7'd25},
    '{7'd8, 7'd17, 7'd23, 7'd25},  '{7'd9, 7'd17, 7'd23, 7'd34},
    '{7'd9, 7'd18, 7'd25, 7'd30},  '{7'd10, 7'd20, 7'd27, 7'd32},
    '{7'd12, 7'd21, 7'd29, 7'd35}, '{7'd12, 7'd23, 7'd34, 7'd37},
    '{7'd12, 7'd25, 7'd34, 7'd40}, '{7'd13, 7'd26, 7'd35, 7'd42},
    '{7'd14, 7'd28, 7'd38, 7'd45}, '{7'd15, 7'd29, 7'd40, 7'd48},
    '{7'd16, 7'd31, 7'd43, 7'd51}, '{7'd17, 7'd33, 7'd45, 7'd54},
    '{7'd18, 7'd35, 7'd48, 7'd57}, '{7'd19, 7'd37, 7'd51, 7'd60},
    '{7'd19, 7'd38, 7'd53, 7'd63}, '{7'd20, 7'd40, 7'd56, 7'd66},
    '{7'd21, 7'd43, 7'd59, 7'd70}, '{7'd22, 7'd45, 7'd62, 7'd74},
    '{7'd24, 7'd47, 7'd65, 7'd77}, '{7'd25, 7'd49, 7'd68, 7'd81}
  };

  localparam logic [0:0] CfgVersion = 1'b0;
  localparam logic [0:0] CfgLevel   = 1'b1;

  typedef enum logic [1:0] {
    MODE_SMALL,
    MODE_LARGE,
    MODE_ERR
  } mode_e;

  typedef struct packed {
    logic [WordW:0]   rem;
    logic [WordW-1:0] qn;
  } div_t;

  // One restoring-division step: dividend bits shift out of qn, quotient in.
  function automatic div_t div_step(div_t cur, logic [WordW-1:0] dvs);
    div_t             nxt;
    logic [WordW:0]   trial;
    trial = {cur.rem[WordW-1:0], cur.qn[WordW-1]};
    if (trial >= {1'b0, dvs}) begin
      nxt.rem = trial - {1'b0, dvs};
      nxt.qn  = {cur.qn[WordW-2:0], 1'b1};
    end else begin
      nxt.rem = trial;
      nxt.qn  = {cur.qn[WordW-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

@@ rtl/qr_codeword_interleave_address_top.sv @@
// Top level: QR codeword interleave address generator.
//
// Maps a bit index of the data or error-word stream of a QR symbol to its
// bit position in the interleaved codeword buffer.
// Channels: config write (cfg_valid_i/cfg_ready_o, index 0 = version,
// 1 = error level), input items (in_*), results (out_*), all valid/ready.
// After reset and after every config write a sequencer derives the block
// layout (capacity, two 12-step divisions by the block count, one product);
// in_ready_o and cfg_ready_o are low while it runs.
// Pipeline: one select stage, twelve divider stages (one quotient bit per
// stage), one multiply stage and the output register: 15 register stages.
// One item per cycle sustained while the receiver keeps accepting results.
// When the receiver stalls with a result held, the whole pipeline freezes
// and in_ready_o drops; nothing is lost or repeated.
// Reset returns version 1, level L and empties the pipeline.
module qr_codeword_interleave_address_top
  import qrci_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [0:0]        cfg_index_i,
  input  logic [VersW-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [IndexW-1:0] bit_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IndexW-1:0] buffer_bit_position_o,
  output logic              past_end_o
);

  localparam int unsigned Steps = WordW;

  typedef enum logic [2:0] {
    S_IDLE, S_CAP, S_SQR, S_TOT, S_DIV1, S_DIV2, S_THR
  } seq_e;

  seq_e              state_q;
  logic [VersW-1:0]  ver_q;
  logic [LevelW-1:0] lvl_q;
  logic [5:0]        vidx_q;
  logic [7:0]        side_q;
  logic [2:0]        n_q;
  logic [15:0]       sq_q;
  logic [5:0]        nn_q;
  div_t              sd_q;
  logic [3:0]        cnt_q;
  logic [WordW-1:0]  dw_q, ew_q, dsmall_q, dlarge_q, ewb_q, thr_q;
  logic [BlockW-1:0] blocks_q, small_q, large_q;
  logic              ewb_zero_q;

  logic        busy;
  logic [5:0]  vc;
  logic [11:0] v37;
  logic [15:0] align, timing, vinfo, func, capbits;
  logic [WordW-1:0] total;
  div_t        sd_nxt;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = !busy;

  always_comb begin
    if (ver_q == 6'd0) vc = 6'd1;
    else if (ver_q > 6'(VersMax)) vc = 6'(VersMax);
    else vc = ver_q;
    v37 = 12'(vc) * 12'd37;   // v / 7 for v <= 40
    align  = (vidx_q != 6'd0) ? 16'(25 * (16'(nn_q) - 16'd3)) : 16'd0;
    timing = (16'(side_q) - 16'd16 -
              ((vidx_q != 6'd0) ? 16'(5 * (16'(n_q) - 16'd2)) : 16'd0)) << 1;
    vinfo  = (vidx_q >= 6'd6) ? VinfoMods : 16'd0;
    func   = FinderMods + align + timing + vinfo + FormatMods;
    capbits = sq_q - func;
    total   = capbits[WordW+2:3];
    sd_nxt  = div_step(sd_q, 12'(blocks_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CAP;
      ver_q   <= 6'd1;
      lvl_q   <= 2'd0;
      cnt_q   <= 4'd0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) begin
            if (cfg_index_i == CfgVersion) ver_q <= cfg_data_i;
            else lvl_q <= cfg_data_i[LevelW-1:0];
            state_q <= S_CAP;
          end
        end
        S_CAP: begin
          vidx_q   <= vc - 6'd1;
          side_q   <= SideBase + {vc, 2'b00};
          n_q      <= 3'(v37[11:8] + 4'd2);
          dw_q     <= DATA_CW_ROM[vc - 6'd1][lvl_q];
          blocks_q <= BLOCKS[vc - 6'd1][lvl_q];
          state_q  <= S_SQR;
        end
        S_SQR: begin
          sq_q    <= 16'(side_q) * 16'(side_q);
          nn_q    <= 6'(n_q) * 6'(n_q);
          state_q <= S_TOT;
        end
        S_TOT: begin
          ew_q    <= total - dw_q;
          sd_q    <= '{rem: '0, qn: dw_q};
          cnt_q   <= 4'd0;
          state_q <= S_DIV1;
        end
        S_DIV1: begin
          sd_q  <= sd_nxt;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'(Steps - 1)) begin
            dsmall_q <= sd_nxt.qn;
            dlarge_q <= sd_nxt.qn + 12'd1;
            large_q  <= sd_nxt.rem[BlockW-1:0];
            small_q  <= blocks_q - sd_nxt.rem[BlockW-1:0];
            sd_q     <= '{rem: '0, qn: ew_q};
            cnt_q    <= 4'd0;
            state_q  <= S_DIV2;
          end
        end
        S_DIV2: begin
          sd_q  <= sd_nxt;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'(Steps - 1)) begin
            ewb_q      <= sd_nxt.qn;
            ewb_zero_q <= (sd_nxt.qn == '0);
            state_q    <= S_THR;
          end
        end
        S_THR: begin
          thr_q   <= 12'(dsmall_q * 12'(small_q));
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------- item pipeline ----------------
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en && !busy;

  logic [WordW-1:0] word;
  assign word = bit_index_i[IndexW-1:3];

  logic             sel_end;
  mode_e            sel_mode;
  logic [WordW-1:0] sel_n, sel_d;

  always_comb begin
    sel_end  = 1'b0;
    sel_mode = MODE_SMALL;
    sel_n    = word;
    sel_d    = dsmall_q;
    if (!kind_i) begin
      sel_end = (word >= dw_q);
      if (word >= thr_q) begin
        sel_mode = MODE_LARGE;
        sel_n    = word - thr_q;
        sel_d    = dlarge_q;
      end
    end else begin
      sel_end  = (word >= ew_q) || ewb_zero_q;
      sel_mode = MODE_ERR;
      sel_d    = ewb_q;
    end
  end

  logic             pv_q   [Steps+1];
  div_t             pd_q   [Steps+1];
  logic [WordW-1:0] pdv_q  [Steps+1];
  mode_e            pm_q   [Steps+1];
  logic             pe_q   [Steps+1];
  logic [2:0]       pb_q   [Steps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= Steps; k++) pv_q[k] <= 1'b0;
    end else if (en) begin
      pv_q[0] <= in_valid_i && in_ready_o;
      for (int k = 1; k <= Steps; k++) pv_q[k] <= pv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pd_q[0]  <= '{rem: '0, qn: sel_n};
      pdv_q[0] <= sel_d;
      pm_q[0]  <= sel_mode;
      pe_q[0]  <= sel_end;
      pb_q[0]  <= bit_index_i[2:0];
      for (int k = 1; k <= Steps; k++) begin
        pd_q[k]  <= div_step(pd_q[k-1], pdv_q[k-1]);
        pdv_q[k] <= pdv_q[k-1];
        pm_q[k]  <= pm_q[k-1];
        pe_q[k]  <= pe_q[k-1];
        pb_q[k]  <= pb_q[k-1];
      end
    end
  end

  // Multiply stage
  logic [WordW-1:0] rem_f, quo_f, lim;
  assign rem_f = pd_q[Steps].rem[WordW-1:0];
  assign quo_f = pd_q[Steps].qn;
  assign lim   = ((rem_f + 12'd1) < dsmall_q) ? rem_f + 12'd1 : dsmall_q;

  logic             mv_q, me_q;
  logic [WordW-1:0] p1_q, p2_q, mq_q, off_q;
  logic [2:0]       mb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      mv_q        <= pv_q[Steps];
      out_valid_o <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (pm_q[Steps] == MODE_LARGE) begin
        p1_q <= 12'(rem_f * 12'(large_q));
        p2_q <= 12'(lim * 12'(small_q));
      end else begin
        p1_q <= 12'(rem_f * 12'(blocks_q));
        p2_q <= '0;
      end
      off_q <= (pm_q[Steps] == MODE_ERR) ? dw_q : '0;
      mq_q  <= quo_f;
      me_q  <= pe_q[Steps];
      mb_q  <= pb_q[Steps];
      past_end_o            <= me_q;
      buffer_bit_position_o <= me_q ? '0 : {12'(p1_q + p2_q + mq_q + off_q), mb_q};
    end
  end

endmodule

@@ sim/tb.sv @@
// Testbench for the QR codeword interleave address generator: directed, random and stall tests.
`timescale 1ns / 1ps

module tb;
  import qrci_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 40;

  typedef struct {
    int unsigned dw, ew, blocks, n_large, n_small, dsmall, ewb;
  } layout_t;

  typedef struct {
    logic [IndexW-1:0] pos;
    logic              past;
  } addr_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [0:0]        cfg_index_i = CfgVersion;
  logic [VersW-1:0]  cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              kind_i = 1'b0;
  logic [IndexW-1:0] bit_index_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [IndexW-1:0] buffer_bit_position_o;
  logic              past_end_o;

  qr_codeword_interleave_address_top dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow copy of the block's registers
  logic [VersW-1:0]  cur_version = 6'd1;
  logic [LevelW-1:0] cur_level   = 2'd0;

  addr_t       expected_addrs[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  bit          hold_on = 1'b0;
  event        start_hold;

  function automatic layout_t symbol_layout();
    layout_t     l;
    int unsigned v, side, n, align, timing, vinfo, func, total;
    v = cur_version;
    if (v < 1) v = 1;
    if (v > VersMax) v = VersMax;
    side   = 17 + 4 * v;
    n      = v > 1 ? v / 7 + 2 : 0;
    align  = v > 1 ? 25 * (n * n - 3) : 0;
    timing = (side - 16 - (v > 1 ? 5 * (n - 2) : 0)) * 2;
    vinfo  = v >= 7 ? 36 : 0;
    func   = 192 + align + timing + vinfo + 31;
    total  = (side * side - func) / 8;
    l.dw      = DATA_CW_ROM[v-1][cur_level];
    l.ew      = total - l.dw;
    l.blocks  = BLOCKS[v-1][cur_level];
    l.n_large = l.dw % l.blocks;
    l.n_small = l.blocks - l.n_large;
    l.dsmall  = l.dw / l.blocks;
    l.ewb     = l.ew / l.blocks;
    return l;
  endfunction

  function automatic addr_t interleave_addr(logic k, logic [IndexW-1:0] idx);
    layout_t     l;
    addr_t       a;
    int unsigned word, bitn, pos, r, col, row, lim;
    l = symbol_layout();
    word = idx / 8;
    bitn = idx % 8;
    pos = 0;
    a.past = 1'b0;
    if (!k) begin
      if (word >= l.dw) a.past = 1'b1;
      else if (word < l.dsmall * l.n_small)
        pos = ((word % l.dsmall) * l.blocks + word / l.dsmall) * 8 + bitn;
      else begin
        r   = word - l.dsmall * l.n_small;
        col = r % (l.dsmall + 1);
        row = r / (l.dsmall + 1);
        lim = col + 1 < l.dsmall ? col + 1 : l.dsmall;
        pos = (l.n_small * lim + l.n_large * col + row) * 8 + bitn;
      end
    end else begin
      if (word >= l.ew || l.ewb == 0) a.past = 1'b1;
      else pos = ((word % l.ewb) * l.blocks + word / l.ewb + l.dw) * 8 + bitn;
    end
    a.pos = a.past ? '0 : pos[IndexW-1:0];
    return a;
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    addr_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_addrs.size() == 0) report("unexpected result", buffer_bit_position_o, 0);
      else begin
        e = expected_addrs.pop_front();
        if (buffer_bit_position_o !== e.pos) report("position", buffer_bit_position_o, e.pos);
        if (past_end_o !== e.past) report("past_end", past_end_o, e.past);
      end
    end
  end

  always @(negedge clk_i)
    out_ready_i <= !hold_on && ($urandom_range(99) >= recv_stall);

  initial begin
    forever begin
      @(start_hold);
      hold_on = 1'b1;
      repeat (300) @(negedge clk_i);
      hold_on = 1'b0;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(logic k, logic [IndexW-1:0] idx);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= k;
    bit_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    expected_addrs.push_back(interleave_addr(k, idx));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_addrs.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [VersW-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgVersion) cur_version = data;
    else cur_level = data[LevelW-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_symbol(int unsigned v, int unsigned lvl);
    write_reg(CfgVersion, v[VersW-1:0]);
    write_reg(CfgLevel, {4'($urandom_range(15)), lvl[LevelW-1:0]});
  endtask

  // boundaries of both streams and of the small/large block split
  task automatic send_edges();
    layout_t l;
    l = symbol_layout();
    send_item(1'b0, IndexW'(l.dw * 8 - 1));
    send_item(1'b0, IndexW'(l.dw * 8));
    send_item(1'b0, IndexW'(l.dsmall * l.n_small * 8));
    send_item(1'b1, IndexW'(l.ew * 8 - 1));
    send_item(1'b1, IndexW'(l.ew * 8));
  endtask

  task automatic test_directed();
    send_idle = 0;
    recv_stall = 0;
    // reset configuration: version 1, level L
    send_item(1'b0, 15'd0);
    send_item(1'b0, 15'd7);
    send_item(1'b1, 15'd0);
    send_item(1'b0, 15'h7fff);
    send_item(1'b1, 15'h7fff);
    send_edges();
    set_symbol(40, 3);
    send_edges();
    send_item(1'b0, 15'h5555);
    set_symbol(0, 1);  // version 0 acts as 1
    send_edges();
    set_symbol(63, 2); // clamps to 40
    send_edges();
    send_item(1'b1, 15'h2aaa);
    drain();
  endtask

  task automatic test_random();
    layout_t     l;
    logic        k;
    int unsigned span;
    for (int p = 0; p < 16; p++) begin
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 67; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 67; end
        default: begin send_idle = 29; recv_stall = 29; end
      endcase
      if (p % 5 == 4) set_symbol($urandom_range(63), $urandom_range(3));
      else set_symbol($urandom_range(40, 1), $urandom_range(3));
      l = symbol_layout();
      for (int i = 0; i < 112; i++) begin
        k = 1'($urandom_range(1));
        span = (k ? l.ew : l.dw) * 8 + 15;
        if ($urandom_range(99) < 75) send_item(k, IndexW'($urandom_range(span)));
        else send_item(k, IndexW'($urandom));
      end
    end
    drain();
  endtask

  // receiver holds off long enough for the pipeline to fill and stall input
  task automatic test_backpressure();
    layout_t l;
    send_idle = 0;
    recv_stall = 10;
    set_symbol(27, 1);
    l = symbol_layout();
    -> start_hold;
    for (int i = 0; i < 80; i++)
      send_item(1'($urandom_range(1)), IndexW'($urandom_range(l.dw * 8 + 8)));
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    if (mismatches == 0 && expected_addrs.size() == 0) $display("tb OK");
    else begin
      if (expected_addrs.size() != 0) report("results missing", 0, expected_addrs.size());
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
